/* hdl/ellipse_fit_quality_defines.svh */
// Assertion macros for the ellipse fit quality block.
`ifndef ELLIPSE_FIT_QUALITY_DEFINES_SVH
`define ELLIPSE_FIT_QUALITY_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define EFQ_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define EFQ_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

/* hdl/efq_pkg.sv */
// Shared types and constants for the ellipse fit quality block.
package efq_pkg;

  localparam int MaxPoints = 4096;
  localparam int CountW = $clog2(MaxPoints + 1);
  localparam logic [35:0] QMax = '1;

  localparam logic [2:0] RegCenterX = 3'd0;
  localparam logic [2:0] RegCenterY = 3'd1;
  localparam logic [2:0] RegCos = 3'd2;
  localparam logic [2:0] RegSin = 3'd3;
  localparam logic [2:0] RegInvA = 3'd4;
  localparam logic [2:0] RegInvB = 3'd5;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  typedef struct packed {
    logic [12:0] point_x;
    logic [12:0] point_y;
    logic last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [17:0] fit_ratio;
    logic [12:0] points_seen;
    logic [1:0] fit_status;
  } out_item_t;

  typedef struct packed {
    logic [20:0] center_x;
    logic [20:0] center_y;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic [31:0] inv_a_sq;
    logic [31:0] inv_b_sq;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture point
    logic rot;        // rotate
    logic sq;         // round magnitudes
    logic scale;      // square magnitudes
    logic qsum;       // scale by inverse squares, arm sqrt
    logic sqrt_step;  // one sqrt iteration
    logic acc;        // accumulate sums
    logic skip;       // point dropped, flag overflow
    logic div_start;  // start ratio
    logic div_step;   // one division iteration
    logic finish;     // form result, clear sums
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;       // count reached limit
    logic sqrt_done;
    logic div_done;
  } stat_t;

endpackage

/* hdl/efq_datapath.sv */
// Datapath: rotation, squared radius, square root, sums and final ratio.
module efq_datapath import efq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_item_t result
);

  logic signed [22:0] dx, dy;
  logic signed [39:0] rx, ry;
  logic [25:0] mx, my;
  logic [51:0] mx2, my2;
  logic [35:0] tx, ty;
  logic [59:0] sq_rem, sq_res;
  logic [4:0] sq_cnt;
  logic [35:0] q;
  logic [47:0] radius_sum;
  logic signed [47:0] score_sum;
  logic [CountW-1:0] point_count;
  logic overflowed;
  logic [48:0] div_rem;
  logic [48:0] div_den;
  logic [15:0] div_fr;
  logic div_ip, div_neg, div_sat;
  logic [4:0] div_cnt;

  // products, one multiply per term per cycle
  logic signed [38:0] p1, p2, p3, p4;
  logic [36:0] sx, sy;

  function automatic logic [25:0] round_mag(input logic signed [39:0] v);
    logic [39:0] m;
    logic [39:0] r;
    begin
      m = v[39] ? 40'(-v) : 40'(v);
      r = (m + 40'd8192) >> 14;
      round_mag = r[25:0];
    end
  endfunction

  function automatic logic [36:0] scale_term(input logic [51:0] m2, input logic [31:0] inv);
    logic [67:0] a, b;
    logic [67:0] r;
    begin
      a = 68'(m2) * 68'(inv[31:16]);
      b = 68'(m2) * 68'(inv[15:0]);
      r = (a >> 8) + (b >> 24) + ((68'(b[23:0]) + (68'(a[7:0]) << 16)) >> 24);
      scale_term = (r > 68'(QMax)) ? 37'(QMax) : 37'(r);
    end
  endfunction

  assign p1 = 39'(dx) * 39'(cfg.cos_angle);
  assign p2 = 39'(dy) * 39'(cfg.sin_angle);
  assign p3 = 39'(dx) * 39'(cfg.sin_angle);
  assign p4 = 39'(dy) * 39'(cfg.cos_angle);
  assign sx = scale_term(mx2, cfg.inv_a_sq);
  assign sy = scale_term(my2, cfg.inv_b_sq);

  logic [37:0] qs;
  assign qs = 38'(tx) + 38'(ty);

  // restoring sqrt trial; step count k works on bit pair k-1
  logic [4:0] sq_bit;
  logic [59:0] trial;
  assign sq_bit = sq_cnt - 5'd1;
  assign trial = sq_res + (60'd1 << {sq_bit, 1'b0});

  // division trial
  logic [49:0] dshift;
  assign dshift = {div_rem, 1'b0};

  logic signed [48:0] ssum_ext;
  logic signed [48:0] score_val;
  logic [48:0] rsum_ext;
  logic [47:0] abs_s;
  assign score_val = 49'(signed'({1'b0, sq_res[29:0], 1'b0})) - 49'(1 << 24);
  assign ssum_ext = 49'(score_sum) + score_val;
  assign rsum_ext = 49'(radius_sum) + 49'(q);
  assign abs_s = score_sum[47] ? 48'(-score_sum) : score_sum;

  assign stat.full = (point_count == CountW'(MaxPoints));
  assign stat.sqrt_done = (sq_cnt == 5'd0);
  assign stat.div_done = (div_cnt == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sum <= '0;
      score_sum <= '0;
      point_count <= '0;
      overflowed <= 1'b0;
    end else begin
      if (cmd.load) begin
        dx <= 23'(signed'({1'b0, item.point_x, 8'd0})) - 23'(signed'({1'b0, cfg.center_x}));
        dy <= 23'(signed'({1'b0, item.point_y, 8'd0})) - 23'(signed'({1'b0, cfg.center_y}));
      end
      if (cmd.rot) begin
        rx <= 40'(p1) - 40'(p2);
        ry <= 40'(p3) + 40'(p4);
      end
      if (cmd.sq) begin
        mx <= round_mag(rx);
        my <= round_mag(ry);
      end
      if (cmd.scale) begin
        mx2 <= 52'(mx) * 52'(mx);
        my2 <= 52'(my) * 52'(my);
      end
      if (cmd.qsum) begin
        tx <= sx[35:0];
        ty <= sy[35:0];
      end
      if (cmd.sqrt_step && sq_cnt == 5'd31) begin
        // load: q << 24 into remainder, 30 bit pairs to go
        q <= (qs > 38'(QMax)) ? QMax : qs[35:0];
        sq_rem <= {((qs > 38'(QMax)) ? QMax : qs[35:0]), 24'd0};
        sq_res <= '0;
        sq_cnt <= 5'd30;
      end else if (cmd.sqrt_step) begin
        if (sq_rem >= trial) begin
          sq_rem <= sq_rem - trial;
          sq_res <= (sq_res >> 1) + (60'd1 << {sq_bit, 1'b0});
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_cnt <= sq_cnt - 5'd1;
      end
      if (cmd.qsum) sq_cnt <= 5'd31;
      if (cmd.acc) begin
        radius_sum <= rsum_ext[48] ? '1 : rsum_ext[47:0];
        if (ssum_ext > 49'sh7FFF_FFFF_FFFF) score_sum <= 48'sh7FFF_FFFF_FFFF;
        else if (ssum_ext < -49'sh8000_0000_0000) score_sum <= 48'sh8000_0000_0000;
        else score_sum <= ssum_ext[47:0];
        point_count <= point_count + 1'b1;
      end
      if (cmd.skip) overflowed <= 1'b1;
      if (cmd.div_start) begin
        div_neg <= score_sum[47];
        div_den <= 49'(radius_sum);
        div_sat <= (49'(abs_s) >= {radius_sum, 1'b0});
        div_ip <= (abs_s >= radius_sum);
        div_rem <= (abs_s >= radius_sum) ? 49'(abs_s - radius_sum) : 49'(abs_s);
        div_fr <= '0;
        div_cnt <= 5'd16;
      end else if (cmd.div_step) begin
        if (50'(dshift) >= 50'(div_den)) begin
          div_rem <= 49'(dshift - 50'(div_den));
          div_fr <= {div_fr[14:0], 1'b1};
        end else begin
          div_rem <= dshift[48:0];
          div_fr <= {div_fr[14:0], 1'b0};
        end
        div_cnt <= div_cnt - 5'd1;
      end
      if (cmd.finish) begin
        result.points_seen <= (point_count > CountW'(8191)) ? 13'd8191 : 13'(point_count);
        if (radius_sum == '0) begin
          result.fit_ratio <= '0;
          result.fit_status <= StatusEmpty;
        end else begin
          result.fit_status <= StatusOk;
          if (div_sat) result.fit_ratio <= div_neg ? -18'sd131072 : 18'sd65536;
          else if (div_neg) result.fit_ratio <= -18'(signed'({1'b0, div_ip, div_fr}));
          else if (div_ip && div_fr != '0) result.fit_ratio <= 18'sd65536;
          else result.fit_ratio <= 18'(signed'({1'b0, div_ip, div_fr}));
        end
        if (overflowed || cmd.skip) result.fit_status <= StatusOverflow;
        radius_sum <= '0;
        score_sum <= '0;
        point_count <= '0;
        overflowed <= 1'b0;
      end
    end
  end

endmodule

/* hdl/efq_control.sv */
// Controller: sequences one point through the datapath and hands off results.
module efq_control import efq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  last_point,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_SQ, S_SCALE, S_QSUM, S_SQRT, S_ACC, S_DIV, S_FIN
  } state_t;

  state_t state;
  logic last;
  logic div_started;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        cmd.skip = in_valid && stat.full;
      end
      S_ROT: cmd.rot = 1'b1;
      S_SQ: cmd.sq = 1'b1;
      S_SCALE: cmd.scale = 1'b1;
      S_QSUM: cmd.qsum = 1'b1;
      S_SQRT: cmd.sqrt_step = !stat.sqrt_done;
      S_ACC: cmd.acc = 1'b1;
      S_DIV: begin
        cmd.div_start = !div_started;
        cmd.div_step = div_started && !stat.div_done;
      end
      // result register must be free or taken at this edge
      S_FIN: cmd.finish = !out_valid || !out_stall;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      last <= 1'b0;
      div_started <= 1'b0;
    end else begin
      out_valid <= cmd.finish || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last <= last_point;
            if (stat.full) state <= last_point ? S_DIV : S_IDLE;
            else state <= S_ROT;
            div_started <= 1'b0;
          end
        end
        S_ROT: state <= S_SQ;
        S_SQ: state <= S_SCALE;
        S_SCALE: state <= S_QSUM;
        S_QSUM: state <= S_SQRT;
        S_SQRT: if (stat.sqrt_done) state <= S_ACC;
        S_ACC: state <= last ? S_DIV : S_IDLE;
        S_DIV: begin
          div_started <= 1'b1;
          if (div_started && stat.div_done) state <= S_FIN;
        end
        S_FIN: if (cmd.finish) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/ellipse_fit_quality.sv */
// Ellipse fit quality block: top level with configuration registers.
// Scores contour points against a configured ellipse. Points accumulate until
// one marked last; that transaction yields one result (ratio, count, status)
// and clears the sums. A point is taken, then rotated, rounded, squared and
// scaled, run through the bit-pair square root (load, 30 steps, done) and
// accumulated; input stalls until it is through. A point marked last then
// runs the restoring division and forms the result. A point past the limit
// is dropped without leaving idle unless it is marked last. The result waits
// in an output register until taken; points keep flowing meanwhile, and only
// the next last point holds off forming its result, stalling input.
`include "ellipse_fit_quality_defines.svh"
module ellipse_fit_quality import efq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  cfg_t cfg;
  cmd_t cmd;
  stat_t stat;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.cos_angle <= 16'sd16384;
      cfg.sin_angle <= '0;
      cfg.inv_a_sq <= '0;
      cfg.inv_b_sq <= '0;
    end else if (wr) begin
      case (paddr[4:2])
        RegCenterX: cfg.center_x <= pwdata[20:0];
        RegCenterY: cfg.center_y <= pwdata[20:0];
        RegCos: cfg.cos_angle <= pwdata[15:0];
        RegSin: cfg.sin_angle <= pwdata[15:0];
        RegInvA: cfg.inv_a_sq <= pwdata;
        RegInvB: cfg.inv_b_sq <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegCenterX: prdata = 32'(cfg.center_x);
      RegCenterY: prdata = 32'(cfg.center_y);
      RegCos: prdata = 32'(signed'(cfg.cos_angle));
      RegSin: prdata = 32'(signed'(cfg.sin_angle));
      RegInvA: prdata = cfg.inv_a_sq;
      RegInvB: prdata = cfg.inv_b_sq;
      default: prdata = '0;
    endcase
  end

  efq_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .last_point(in_data.last_point),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  efq_datapath u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .item(in_data), .cmd(cmd),
    .stat(stat), .result(out_data)
  );

  `EFQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `EFQ_ASSERT_IMPL(a_status_code, out_valid, out_data.fit_status <= StatusOverflow)
  `EFQ_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({cmd.rot, cmd.sq, cmd.acc, cmd.finish}))

endmodule

/* dv/tb_ellipse_fit_quality.sv */
// Self-checking testbench for the ellipse fit quality scorer.
`timescale 1ns / 1ps
module tb_ellipse_fit_quality import efq_pkg::*; ();

  localparam int DrainCycles = 120;
  localparam int WatchLimit = 20000;
  localparam longint unsigned QSat = (64'd1 << 36) - 1;
  localparam longint unsigned RadiusSat = (64'd1 << 48) - 1;
  localparam longint SumHi = (64'sd1 <<< 47) - 1;
  localparam longint SumLo = -(64'sd1 <<< 47);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  ellipse_fit_quality dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  cfg_t cfg;
  longint unsigned radius_acc;
  longint score_acc;
  int unsigned npoints;
  bit dropped;
  out_item_t fits_due[$];
  int errors = 0;
  int idle_in_pct = 0, idle_out_pct = 0;
  bit hold_off = 1'b0;
  int quiet = 0;

  function automatic longint unsigned round_q8(longint v);
    longint unsigned m;
    m = v < 0 ? -v : v;
    return (m + 8192) >> 14;
  endfunction

  function automatic longint unsigned scaled_sq(longint unsigned m2, bit [31:0] inv);
    logic [127:0] p;
    p = (m2 * inv) >> 24;
    return p > QSat ? QSat : p[63:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      b = r | (64'd1 << i);
      if (b * b <= v) r = b;
    end
    return r;
  endfunction

  function automatic logic signed [17:0] fit_q16(longint num, longint unsigned den);
    longint unsigned mag, r;
    mag = num < 0 ? -num : num;
    if (mag >= 2 * den) return num < 0 ? -18'sd131072 : 18'sd65536;
    r = (128'(mag) << 16) / den;
    if (num < 0) return 18'(-r);
    return r > 65536 ? 18'sd65536 : 18'(r);
  endfunction

  task automatic score_point(in_item_t it);
    longint dx, dy, sc;
    longint unsigned mx, my, q;
    out_item_t r;
    if (npoints >= MaxPoints) dropped = 1'b1;
    else begin
      dx = longint'(it.point_x) * 256 - longint'(cfg.center_x);
      dy = longint'(it.point_y) * 256 - longint'(cfg.center_y);
      mx = round_q8(dx * cfg.cos_angle - dy * cfg.sin_angle);
      my = round_q8(dx * cfg.sin_angle + dy * cfg.cos_angle);
      q = scaled_sq(mx * mx, cfg.inv_a_sq) + scaled_sq(my * my, cfg.inv_b_sq);
      if (q > QSat) q = QSat;
      sc = 2 * longint'(root_floor(q << 24)) - (64'sd1 <<< 24);
      radius_acc += q;
      if (radius_acc > RadiusSat) radius_acc = RadiusSat;
      score_acc += sc;
      if (score_acc > SumHi) score_acc = SumHi;
      if (score_acc < SumLo) score_acc = SumLo;
      npoints++;
    end
    if (it.last_point) begin
      r.points_seen = 13'(npoints > 8191 ? 8191 : npoints);
      r.fit_status = StatusOk;
      r.fit_ratio = '0;
      if (radius_acc == 0) r.fit_status = StatusEmpty;
      else r.fit_ratio = fit_q16(score_acc, radius_acc);
      if (dropped) r.fit_status = StatusOverflow;
      fits_due = {fits_due, r};
      radius_acc = 0; score_acc = 0; npoints = 0; dropped = 1'b0;
    end
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegCenterX: cfg.center_x = val[20:0];
      RegCenterY: cfg.center_y = val[20:0];
      RegCos: cfg.cos_angle = val[15:0];
      RegSin: cfg.sin_angle = val[15:0];
      RegInvA: cfg.inv_a_sq = val;
      default: cfg.inv_b_sq = val;
    endcase
    @(posedge clk);
  endtask

  // valid stays up between back-to-back points; dropped only when idling
  task automatic send_point(in_item_t it);
    if (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_in_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    score_point(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (fits_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_ellipse(bit [20:0] cx, bit [20:0] cy, bit [15:0] c, bit [15:0] s,
                                 bit [31:0] ia, bit [31:0] ib);
    reg_write(RegCenterX, 32'(cx)); reg_write(RegCenterY, 32'(cy));
    reg_write(RegCos, 32'(c)); reg_write(RegSin, 32'(s));
    reg_write(RegInvA, ia); reg_write(RegInvB, ib);
  endtask

  function automatic in_item_t pt(int x, int y, bit l);
    in_item_t it;
    it.point_x = 13'(x); it.point_y = 13'(y); it.last_point = l;
    return it;
  endfunction

  // receiver
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (fits_due.size() == 0) begin
          $error("unexpected fit result"); errors++;
        end else begin
          out_item_t e;
          e = fits_due.pop_front();
          if (out_data.fit_ratio !== e.fit_ratio) begin
            $error("fit_ratio exp %0d got %0d", e.fit_ratio, out_data.fit_ratio); errors++;
          end
          if (out_data.points_seen !== e.points_seen) begin
            $error("points_seen exp %0d got %0d", e.points_seen, out_data.points_seen);
            errors++;
          end
          if (out_data.fit_status !== e.fit_status) begin
            $error("fit_status exp %0d got %0d", e.fit_status, out_data.fit_status); errors++;
          end
        end
      end
      out_stall <= hold_off || (idle_out_pct > 0 && $urandom_range(99) < idle_out_pct);
    end
  end

  // watchdog on stalled progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  typedef struct {
    in_item_t pnt;
    bit check_fixed;
    out_item_t fixed;
  } stim_row_t;

  stim_row_t directed[$];

  initial begin
    int n, len, mode;
    bit [20:0] cx, cy;
    cfg = '{center_x: 0, center_y: 0, cos_angle: 16384, sin_angle: 0,
            inv_a_sq: 0, inv_b_sq: 0};
    radius_acc = 0; score_acc = 0; npoints = 0; dropped = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset inverses are zero: every contour scores empty
    directed = {directed,
                stim_row_t'{pt(0, 0, 1), 1'b1, out_item_t'{18'sd0, 13'd1, StatusEmpty}}};
    directed = {directed, stim_row_t'{pt(8191, 8191, 0), 1'b0, '0}};
    directed = {directed,
                stim_row_t'{pt(8191, 0, 1), 1'b1, out_item_t'{18'sd0, 13'd2, StatusEmpty}}};
    foreach (directed[i]) begin
      send_point(directed[i].pnt);
      if (directed[i].check_fixed && fits_due[$] !== directed[i].fixed) begin
        $error("directed row %0d mismatch", i); errors++;
      end
    end
    wait_idle();

    // 45-degree ellipse centred at (100, 100), extreme trig, plain sines
    program_ellipse(21'd100 << 8, 21'd100 << 8, 16'd11585, 16'd11585,
                    32'd429497, 32'd858993);
    send_point(pt(100, 100, 1));
    send_point(pt(110, 100, 0)); send_point(pt(90, 105, 0));
    send_point(pt(100, 90, 1));
    send_point(pt(0, 0, 0)); send_point(pt(8191, 8191, 1));
    wait_idle();
    program_ellipse('1, '1, 16'h8000, 16'h7fff, '1, '1);
    send_point(pt(0, 0, 0)); send_point(pt(8191, 0, 0)); send_point(pt(0, 8191, 1));
    send_point(pt(2047, 4095, 1));
    wait_idle();
    program_ellipse('0, '0, -16'sd16384, 16'd16384, 32'd1, 32'd0);
    send_point(pt(1, 1, 1)); send_point(pt(5000, 3, 1));
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      idle_in_pct = ph == 0 ? 15 : ph == 1 ? 76 : 0;
      idle_out_pct = ph == 0 ? 76 : ph == 1 ? 15 : 0;
      cx = 21'($urandom_range(2097151)); cy = 21'($urandom_range(2097151));
      program_ellipse(cx, cy, 16'($urandom), 16'($urandom),
                      ph == 2 ? 32'hffffffff : $urandom_range(100000),
                      ph == 2 ? 32'h0 : $urandom);
      n = 0;
      while (n < 580) begin
        len = $urandom_range(1, 12);
        mode = $urandom_range(9);
        for (int k = 0; k < len; k++) begin
          if (mode < 7)
            send_point(pt((cx >> 8) + $urandom_range(200) - 100,
                          (cy >> 8) + $urandom_range(200) - 100, k == len - 1));
          else
            send_point(pt($urandom, $urandom, k == len - 1));
          n++;
        end
        if (ph == 2 && n > 300 && n < 320) begin
          // hold the receiver while points keep arriving
          hold_off = 1'b1;
          fork
            begin repeat (400) @(posedge clk); hold_off = 1'b0; end
            for (int k = 0; k < 6; k++) send_point(pt($urandom, $urandom, 1));
          join
          n += 6;
        end
      end
      wait_idle();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
